>>> src/escaped_frame_receiver_top_macros.svh
// Assertion macros for the escaped frame receiver.
// Used by escaped_frame_receiver_top; needs no other file.
`ifndef ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define EFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/efr_pkg.sv
// Shared constants, register indexes and controller/datapath structs
// for the escaped frame receiver. No dependencies.
package efr_pkg;

    localparam int CONTENT_DEPTH_DEF = 64;
    localparam int FRAME_OVERHEAD    = 3;
    localparam int MAX_PAYLOAD       = 61;

    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 6;
    localparam int IDX_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LITERAL = 2'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'd27;
    localparam logic [BYTE_W-1:0] START_RST   = 8'd2;
    localparam logic [BYTE_W-1:0] STOP_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] LITERAL_RST = 8'd0;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;       // store the received byte
        logic store_esc;   // store the escape code as a literal
        logic clear;       // empty the content store
        logic drain_init;  // rewind the payload read index
        logic rd;          // read the payload byte at the index
        logic load;        // load a payload result into the output register
        logic load_empty;  // load the empty-payload result
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_esc;
        logic is_start;
        logic is_stop;
        logic is_lit;
        logic frame_ok;
        logic size_zero;
        logic last_read;
        logic out_busy;
    } t_dp_status;

endpackage

>>> src/escaped_frame_receiver_top.sv
// Escaped frame receiver: one link byte per transfer in, one result per
// payload byte out. After an accepted stop code, the first result passes the
// S_READ and S_LOAD states (S_EMPTY if empty) and the output register.
// Throughput: one input byte per cycle while idle; the input is held off while a
// frame drains (a memory read and output load per byte, only a load if empty) and
// while a load waits on a stalled output. Reset is synchronous: it clears control
// state and the code registers; the content memory is not cleared.
`include "escaped_frame_receiver_top_macros.svh"

module escaped_frame_receiver_top #(
    parameter int CONTENT_DEPTH = efr_pkg::CONTENT_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [efr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [efr_pkg::BYTE_W-1:0]           i_cfg_wdata,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [efr_pkg::BYTE_W-1:0]           i_s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [7:0] packet_id, [13:8] payload_size, [21:14] data_byte,
    // [27:22] byte_index, [31:28] zero
    output logic [efr_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                 o_m_axis_tuser,   // [0] has_data
    output logic                                 o_m_axis_tlast
);
    import efr_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_status        w_sts;
    logic [BYTE_W-1:0] w_packet_id;
    logic [SIZE_W-1:0] w_payload_size;
    logic [BYTE_W-1:0] w_data_byte;
    logic [IDX_W-1:0]  w_byte_index;

    efr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    efr_datapath #(
        .CONTENT_DEPTH (CONTENT_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_byte         (i_s_axis_tdata),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_m_ready      (i_m_axis_tready),
        .o_m_valid      (o_m_axis_tvalid),
        .o_packet_id    (w_packet_id),
        .o_payload_size (w_payload_size),
        .o_data_byte    (w_data_byte),
        .o_byte_index   (w_byte_index),
        .o_has_data     (o_m_axis_tuser),
        .o_last         (o_m_axis_tlast)
    );

    // Pack the result fields, lowest first
    assign o_m_axis_tdata = {4'b0000, w_byte_index, w_data_byte, w_payload_size, w_packet_id};

    // A non-final result is only shown mid-drain, with the input held off
    `EFR_ASSERT_IMPL(a_drain_blocks_input, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready,
        "input ready while a frame is draining")
    // An accepted frame holds the input off on the next cycle
    `EFR_ASSERT_NEXT(a_accept_starts_drain, i_clk, i_rst_n,
        w_cmd.drain_init, !o_s_axis_tready,
        "accepted frame did not start a drain")
    // An empty-payload result is always the last of its run
    `EFR_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tlast,
        "empty-payload result without last mark")

endmodule

>>> src/efr_ctrl.sv
// Controller for the escaped frame receiver: escape/frame tracking and
// the payload drain sequence. Depends on efr_pkg.
module efr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  efr_pkg::t_dp_status i_sts,
    output efr_pkg::t_dp_cmd    o_cmd
);
    import efr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_EMPTY
    } t_state;

    t_state r_state, n_state;
    logic   r_armed, n_armed;
    logic   r_open,  n_open;
    logic   w_accept;

    assign o_s_ready = (r_state == S_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;

    // Decode the accepted byte and sequence the drain
    always_comb begin
        n_state = r_state;
        n_armed = r_armed;
        n_open  = r_open;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.is_esc) begin
                        n_armed = 1'b1;
                    end else if (r_armed) begin
                        n_armed = 1'b0;
                        if (i_sts.is_start) begin
                            n_open      = 1'b1;
                            o_cmd.clear = 1'b1;
                        end else if (i_sts.is_stop) begin
                            n_open      = 1'b0;
                            o_cmd.clear = 1'b1;
                            if (i_sts.frame_ok) begin
                                o_cmd.drain_init = 1'b1;
                                n_state = i_sts.size_zero ? S_EMPTY : S_READ;
                            end
                        end else if (i_sts.is_lit) begin
                            o_cmd.store_esc = r_open;
                        end
                    end else begin
                        o_cmd.store = r_open;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.last_read ? S_IDLE : S_READ;
                end
            end
            S_EMPTY: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_empty = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_armed <= 1'b0;
            r_open  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_armed <= n_armed;
            r_open  <= n_open;
        end
    end

endmodule

>>> src/efr_datapath.sv
// Datapath for the escaped frame receiver: code registers, content memory,
// running checksum, frame check and output register. Depends on efr_pkg.
module efr_datapath #(
    parameter int CONTENT_DEPTH = efr_pkg::CONTENT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [efr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [efr_pkg::BYTE_W-1:0]          i_cfg_wdata,
    input  logic [efr_pkg::BYTE_W-1:0]          i_byte,
    input  efr_pkg::t_dp_cmd                    i_cmd,
    output efr_pkg::t_dp_status                 o_sts,
    input  logic                                i_m_ready,
    output logic                                o_m_valid,
    output logic [efr_pkg::BYTE_W-1:0]          o_packet_id,
    output logic [efr_pkg::SIZE_W-1:0]          o_payload_size,
    output logic [efr_pkg::BYTE_W-1:0]          o_data_byte,
    output logic [efr_pkg::IDX_W-1:0]           o_byte_index,
    output logic                                o_has_data,
    output logic                                o_last
);
    import efr_pkg::*;

    localparam int AW = $clog2(CONTENT_DEPTH);
    localparam int CW = $clog2(CONTENT_DEPTH + 1);

    logic [BYTE_W-1:0] r_esc, r_start, r_stop, r_lit;
    logic [CW-1:0]     r_count;
    logic [BYTE_W-1:0] r_acc;
    logic [BYTE_W-1:0] r_id;
    logic [BYTE_W-1:0] r_size;
    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_mem [CONTENT_DEPTH];

    logic              w_full;
    logic              w_wr;
    logic [BYTE_W-1:0] w_wr_byte;
    logic [8:0]        w_rd_addr9;
    logic [AW-1:0]     w_rd_addr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= ESCAPE_RST;
            r_start <= START_RST;
            r_stop  <= STOP_RST;
            r_lit   <= LITERAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ESCAPE:  r_esc   <= i_cfg_wdata;
                REG_START:   r_start <= i_cfg_wdata;
                REG_STOP:    r_stop  <= i_cfg_wdata;
                REG_LITERAL: r_lit   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Drop bytes silently once the store is full
    assign w_full    = (r_count == CW'(CONTENT_DEPTH));
    assign w_wr      = (i_cmd.store || i_cmd.store_esc) && !w_full;
    assign w_wr_byte = i_cmd.store_esc ? r_esc : i_byte;

    // Fill count, id/size capture and checksum over payload plus check byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_acc   <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_acc   <= '0;
        end else if (w_wr) begin
            r_count <= r_count + CW'(1);
            if (r_count >= CW'(2)) begin
                r_acc <= r_acc ^ w_wr_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr && r_count == CW'(0)) begin
            r_id <= w_wr_byte;
        end
        if (w_wr && r_count == CW'(1)) begin
            r_size <= w_wr_byte;
        end
    end

    // Content memory: one write port, one registered read port
    assign w_rd_addr9 = {3'b000, r_idx} + 9'd2;
    assign w_rd_addr  = w_rd_addr9[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_count[AW-1:0]] <= w_wr_byte;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Payload read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.drain_init) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Output register, freed when the downstream side takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_valid <= 1'b0;
        end else if (i_cmd.load || i_cmd.load_empty) begin
            o_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_packet_id    <= r_id;
            o_payload_size <= r_size[SIZE_W-1:0];
            o_data_byte    <= r_rd_data;
            o_byte_index   <= r_idx;
            o_has_data     <= 1'b1;
            o_last         <= o_sts.last_read;
        end else if (i_cmd.load_empty) begin
            o_packet_id    <= r_id;
            o_payload_size <= '0;
            o_data_byte    <= '0;
            o_byte_index   <= '0;
            o_has_data     <= 1'b0;
            o_last         <= 1'b1;
        end
    end

    // Status toward the controller
    always_comb begin
        o_sts.is_esc    = (i_byte == r_esc);
        o_sts.is_start  = (i_byte == r_start);
        o_sts.is_stop   = (i_byte == r_stop);
        o_sts.is_lit    = (i_byte == r_lit);
        o_sts.frame_ok  = (10'(r_count) == 10'(r_size) + 10'(FRAME_OVERHEAD))
                          && (r_size <= BYTE_W'(MAX_PAYLOAD))
                          && (r_acc == '0);
        o_sts.size_zero = (r_size == '0);
        o_sts.last_read = (({2'b00, r_idx} + 8'd1) == r_size);
        o_sts.out_busy  = o_m_valid && !i_m_ready;
    end

endmodule

>>> dv/efr_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the escaped frame receiver: follows every transfer on the
// config port and both streams, decodes the link bytes itself and checks results.
// Depends on efr_pkg for the register indexes, reset codes and field widths.
module efr_frame_checker #(
    parameter int CONTENT_DEPTH = efr_pkg::CONTENT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [efr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [efr_pkg::BYTE_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [efr_pkg::BYTE_W-1:0]        i_s_axis_tdata,   // [7:0] rx_byte
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] packet_id, [13:8] payload_size, [21:14] data_byte,
    // [27:22] byte_index, [31:28] zero
    input  logic [efr_pkg::OUT_DATA_W-1:0]    i_m_axis_tdata,
    input  logic                              i_m_axis_tuser,   // [0] has_data
    input  logic                              i_m_axis_tlast,
    output int                                o_fail_count,
    output int                                o_pending
);
    import efr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_id;
        logic [SIZE_W-1:0] payload_size;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              has_data;
        logic              last;
    } t_frame_result;

    // Shadow of the code registers
    logic [BYTE_W-1:0] escape_code, start_code, stop_code, literal_code;

    // Decoder state
    logic              escape_armed;
    logic              frame_open;
    int unsigned       stored_count;
    logic [BYTE_W-1:0] frame_bytes [CONTENT_DEPTH];

    t_frame_result     expected_results_q[$];
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void store_frame_byte(input logic [BYTE_W-1:0] b);
        if (stored_count < CONTENT_DEPTH) begin
            frame_bytes[stored_count] = b;
            stored_count++;
        end
    endfunction

    // Validate the stored frame on a stop code and queue its payload run
    function automatic void release_frame();
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] xsum;
        int unsigned       size;
        t_frame_result     r;
        if (stored_count < FRAME_OVERHEAD)
            return;
        id   = frame_bytes[0];
        size = 32'(frame_bytes[1]);
        if (stored_count != size + FRAME_OVERHEAD || size > MAX_PAYLOAD)
            return;
        xsum = '0;
        for (int i = 0; i < size; i++)
            xsum ^= frame_bytes[2 + i];
        if (xsum != frame_bytes[stored_count - 1])
            return;
        if (size == 0) begin
            r = '{packet_id: id, payload_size: '0, data_byte: '0, byte_index: '0,
                  has_data: 1'b0, last: 1'b1};
            expected_results_q.push_back(r);
            return;
        end
        for (int i = 0; i < size; i++) begin
            r.packet_id    = id;
            r.payload_size = SIZE_W'(size);
            r.data_byte    = frame_bytes[2 + i];
            r.byte_index   = IDX_W'(i);
            r.has_data     = 1'b1;
            r.last         = (i + 1 == size);
            expected_results_q.push_back(r);
        end
    endfunction

    // Advance the decoder by one link byte
    function automatic void decode_link_byte(input logic [BYTE_W-1:0] b);
        if (b == escape_code) begin
            escape_armed = 1'b1;
            return;
        end
        if (escape_armed) begin
            if (b == start_code) begin
                frame_open   = 1'b1;
                stored_count = 0;
            end else if (b == stop_code) begin
                release_frame();
                frame_open   = 1'b0;
                stored_count = 0;
            end else if (b == literal_code) begin
                if (frame_open)
                    store_frame_byte(escape_code);
            end
            escape_armed = 1'b0;
            return;
        end
        if (frame_open)
            store_frame_byte(b);
    endfunction

    task automatic report_field(input string name, input logic [BYTE_W-1:0] exp_v,
                                input logic [BYTE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result exp_r;
        if (!i_rst_n) begin
            escape_code  = ESCAPE_RST;
            start_code   = START_RST;
            stop_code    = STOP_RST;
            literal_code = LITERAL_RST;
            escape_armed = 1'b0;
            frame_open   = 1'b0;
            stored_count = 0;
            expected_results_q.delete();
        end else begin
            // Check the output transfer against the oldest expectation
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results_q.size() == 0) begin
                    $display("[%0t] unexpected result: expected none, actual tdata=%h",
                             $time, i_m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results_q.pop_front();
                    report_field("packet_id", exp_r.packet_id, i_m_axis_tdata[7:0]);
                    report_field("payload_size", BYTE_W'(exp_r.payload_size),
                                 BYTE_W'(i_m_axis_tdata[13:8]));
                    report_field("data_byte", exp_r.data_byte, i_m_axis_tdata[21:14]);
                    report_field("byte_index", BYTE_W'(exp_r.byte_index),
                                 BYTE_W'(i_m_axis_tdata[27:22]));
                    report_field("has_data", BYTE_W'(exp_r.has_data),
                                 BYTE_W'(i_m_axis_tuser));
                    report_field("last", BYTE_W'(exp_r.last), BYTE_W'(i_m_axis_tlast));
                end
            end
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ESCAPE:  escape_code  = i_cfg_wdata;
                    REG_START:   start_code   = i_cfg_wdata;
                    REG_STOP:    stop_code    = i_cfg_wdata;
                    REG_LITERAL: literal_code = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                decode_link_byte(i_s_axis_tdata);
        end
        o_pending <= expected_results_q.size();
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the escaped frame receiver testbench: clock, reset, code register
// writes and byte stimulus. Depends on efr_pkg, the DUT and efr_frame_checker.
module tb_top;
    import efr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_SIZE,
        FLAW_NO_STOP,
        FLAW_OVERFLOW
    } t_frame_flaw;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = REG_ESCAPE;
    logic [BYTE_W-1:0]     i_cfg_wdata     = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [BYTE_W-1:0]     i_s_axis_tdata  = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    int fail_count;
    int results_pending;

    // Codes currently programmed, used to build well-formed frames
    logic [BYTE_W-1:0] cur_esc, cur_start, cur_stop, cur_lit;

    int bytes_sent    = 0;
    bit input_gaps    = 1'b1;
    bit output_stalls = 1'b1;
    int idle_cycles   = 0;

    escaped_frame_receiver_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    efr_frame_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Throttle the result stream
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            gap = output_stalls ? pick_gap() : 0;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Abort when neither stream nor the config port moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Send one link byte, with an optional gap before it
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = input_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_code(input logic [BYTE_W-1:0] code);
        push_byte(cur_esc);
        push_byte(code);
    endtask

    // Frame content: escape bytes travel as escape + literal code
    task automatic send_content(input logic [BYTE_W-1:0] b);
        if (b == cur_esc) begin
            push_byte(cur_esc);
            push_byte(cur_lit);
        end else begin
            push_byte(b);
        end
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] id, input int size,
                              input t_frame_flaw flaw);
        logic [BYTE_W-1:0] xsum;
        logic [BYTE_W-1:0] b;
        xsum = '0;
        send_code(cur_start);
        send_content(id);
        send_content((flaw == FLAW_SIZE) ? BYTE_W'(size + 1) : BYTE_W'(size));
        for (int i = 0; i < size; i++) begin
            b = ($urandom_range(0, 7) == 0) ? cur_esc : BYTE_W'($urandom);
            xsum ^= b;
            send_content(b);
        end
        if (flaw == FLAW_CHECKSUM)
            xsum ^= BYTE_W'(1 << $urandom_range(0, 7));
        send_content(xsum);
        if (flaw == FLAW_OVERFLOW)
            repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom));
        if (flaw != FLAW_NO_STOP)
            send_code(cur_stop);
    endtask

    // Hold off until every expected result is out and the block has settled
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic [BYTE_W-1:0] esc, input logic [BYTE_W-1:0] st,
                               input logic [BYTE_W-1:0] sp, input logic [BYTE_W-1:0] lit);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_ESCAPE;
        i_cfg_wdata <= esc;
        @(posedge i_clk);
        i_cfg_index <= REG_START;
        i_cfg_wdata <= st;
        @(posedge i_clk);
        i_cfg_index <= REG_STOP;
        i_cfg_wdata <= sp;
        @(posedge i_clk);
        i_cfg_index <= REG_LITERAL;
        i_cfg_wdata <= lit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_esc   = esc;
        cur_start = st;
        cur_stop  = sp;
        cur_lit   = lit;
    endtask

    // Random traffic: mostly good frames, some broken ones and line noise
    task automatic random_traffic(input int end_count);
        int kind;
        t_frame_flaw flaw;
        while (bytes_sent < end_count) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                send_frame(BYTE_W'($urandom), $urandom_range(0, 6), FLAW_NONE);
            end else if (kind < 68) begin
                if ($urandom_range(0, 2) == 0)
                    send_frame(BYTE_W'($urandom), MAX_PAYLOAD,
                               $urandom_range(0, 1) ? FLAW_OVERFLOW : FLAW_NONE);
                else
                    send_frame(BYTE_W'($urandom), $urandom_range(7, MAX_PAYLOAD), FLAW_NONE);
            end else if (kind < 85) begin
                flaw = t_frame_flaw'($urandom_range(FLAW_CHECKSUM, FLAW_OVERFLOW));
                send_frame(BYTE_W'($urandom), $urandom_range(0, 6), flaw);
            end else if (kind < 93) begin
                send_code(BYTE_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) push_byte(BYTE_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] e, s, t, l;
        cur_esc   = ESCAPE_RST;
        cur_start = START_RST;
        cur_stop  = STOP_RST;
        cur_lit   = LITERAL_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stop with no open frame, line noise, escape while armed
        // followed by an unknown code, empty payload, an escaped escape byte
        send_code(cur_stop);
        push_byte(8'hFF);
        push_byte(cur_esc);
        send_code(8'h55);
        send_frame(8'h00, 0, FLAW_NONE);
        send_code(cur_start);
        send_content(8'hFF);
        send_content(8'd1);
        send_content(cur_esc);
        send_content(cur_esc);
        send_code(cur_stop);

        // Extreme code values
        write_codes(8'hFF, 8'h00, 8'hFE, 8'h01);
        input_gaps    = 1'b1;
        output_stalls = 1'b1;
        random_traffic(bytes_sent + 85);

        write_codes(8'h00, 8'hFF, 8'h01, 8'h80);
        input_gaps    = 1'b0;
        random_traffic(bytes_sent + 85);

        // Coinciding codes: start shadows stop, literal equals escape
        e = BYTE_W'($urandom);
        s = e ^ 8'h5A;
        write_codes(e, s, s, e);
        input_gaps = 1'b1;
        random_traffic(bytes_sent + 40);

        // Random distinct codes
        repeat (2) begin
            e = BYTE_W'($urandom);
            do s = BYTE_W'($urandom); while (s == e);
            do t = BYTE_W'($urandom); while (t == e || t == s);
            do l = BYTE_W'($urandom); while (l == e || l == s || l == t);
            write_codes(e, s, t, l);
            output_stalls = ~output_stalls;
            random_traffic(bytes_sent + 85);
        end

        // Back to the reset codes
        write_codes(ESCAPE_RST, START_RST, STOP_RST, LITERAL_RST);
        output_stalls = 1'b1;
        random_traffic(bytes_sent + 85);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
